// ===== rtl/core/heading_pid_angle_wrap_assert.svh =====
// ---------------------------------------------------------------------------
// heading_pid_angle_wrap assertion macros
// shared property wrappers, clocked on i_clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef HEADING_PID_ANGLE_WRAP_ASSERT_SVH
`define HEADING_PID_ANGLE_WRAP_ASSERT_SVH

// same-cycle implication
`define HPAW_ASSERT_IMPL(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error("hpaw port check failed");

// next-cycle implication
`define HPAW_ASSERT_NEXT(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |=> (CONS)) \
        else $error("hpaw port check failed");

`endif

// ===== rtl/core/hpaw_pkg.sv =====
// ---------------------------------------------------------------------------
// hpaw_pkg
// shared widths, word types and register codes of the heading controller
// ---------------------------------------------------------------------------
package hpaw_pkg;

    localparam int ANGLE_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 24;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_P_W   = GAIN_W + ANGLE_W;
    localparam int PROD_I_W   = GAIN_W + SUM_W;
    localparam int PROD_D_W   = GAIN_W + ANGLE_W;
    localparam int ACC_W      = PROD_I_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_UPPER = 3'd3,
        CFG_INTEGRAL_LOWER = 3'd4,
        CFG_DRIVE_UPPER    = 3'd5,
        CFG_DRIVE_LOWER    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [SUM_W-1:0]   integral_upper;
        logic signed [SUM_W-1:0]   integral_lower;
        logic signed [DRIVE_W-1:0] drive_upper;
        logic signed [DRIVE_W-1:0] drive_lower;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_p:         16'sd256,
        gain_i:         16'sd0,
        gain_d:         16'sd0,
        integral_upper: 24'sd1000000,
        integral_lower: -24'sd1000000,
        drive_upper:    16'sd10000,
        drive_lower:    -16'sd10000
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] target_heading;
        logic signed [ANGLE_W-1:0] measured_heading;
    } t_in_word;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_value;
        logic                      drive_saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] err;
        logic signed [ANGLE_W-1:0] derr;
        logic signed [SUM_W-1:0]   sum;
    } t_err_word;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } t_prod_word;

endpackage

// ===== rtl/core/hpaw_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// hpaw_cfg_regs
// gain and clamp registers, written through a plain write port
// ---------------------------------------------------------------------------
module hpaw_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [hpaw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hpaw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output hpaw_pkg::t_cfg                    o_cfg
);

    localparam int GW = hpaw_pkg::GAIN_W;
    localparam int SW = hpaw_pkg::SUM_W;
    localparam int DW = hpaw_pkg::DRIVE_W;

    hpaw_pkg::t_cfg r_cfg;
    hpaw_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (hpaw_pkg::t_cfg_idx'(i_cfg_idx))
                hpaw_pkg::CFG_GAIN_P:         n_cfg.gain_p         = i_cfg_data[GW-1:0];
                hpaw_pkg::CFG_GAIN_I:         n_cfg.gain_i         = i_cfg_data[GW-1:0];
                hpaw_pkg::CFG_GAIN_D:         n_cfg.gain_d         = i_cfg_data[GW-1:0];
                hpaw_pkg::CFG_INTEGRAL_UPPER: n_cfg.integral_upper = i_cfg_data[SW-1:0];
                hpaw_pkg::CFG_INTEGRAL_LOWER: n_cfg.integral_lower = i_cfg_data[SW-1:0];
                hpaw_pkg::CFG_DRIVE_UPPER:    n_cfg.drive_upper    = i_cfg_data[DW-1:0];
                hpaw_pkg::CFG_DRIVE_LOWER:    n_cfg.drive_lower    = i_cfg_data[DW-1:0];
                default:                      n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= hpaw_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/hpaw_err_stage.sv =====
// ---------------------------------------------------------------------------
// hpaw_err_stage
// wrapped error, wrapped error change and clamped integral; owns the state
// ---------------------------------------------------------------------------
module hpaw_err_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  hpaw_pkg::t_in_word    i_word,
    input  hpaw_pkg::t_cfg        i_cfg,
    input  logic                  i_nxt_rdy,
    output logic                  o_rdy,
    output logic                  o_vld,
    output hpaw_pkg::t_err_word   o_word
);

    localparam int AW = hpaw_pkg::ANGLE_W;
    localparam int SW = hpaw_pkg::SUM_W;
    localparam int WW = AW + 2;
    localparam int XW = SW + 1;

    localparam logic signed [WW-1:0] HALF_TURN     = 18'sd18000;
    localparam logic signed [WW-1:0] NEG_HALF_TURN = -18'sd18000;
    localparam logic signed [WW-1:0] FULL_TURN     = 18'sd36000;
    localparam logic signed [WW-1:0] TWO_TURN      = 18'sd72000;
    localparam logic signed [WW-1:0] EDGE_1P5      = 18'sd54000;
    localparam logic signed [WW-1:0] NEG_EDGE_1P5  = -18'sd54000;

    // at most two turns away for any pair of 16-bit headings
    function automatic logic signed [AW-1:0] f_wrap(input logic signed [WW-1:0] a);
        logic signed [WW-1:0] w;
        if (a > EDGE_1P5) begin
            w = a - TWO_TURN;
        end else if (a > HALF_TURN) begin
            w = a - FULL_TURN;
        end else if (a < NEG_EDGE_1P5) begin
            w = a + TWO_TURN;
        end else if (a < NEG_HALF_TURN) begin
            w = a + FULL_TURN;
        end else begin
            w = a;
        end
        return w[AW-1:0];
    endfunction

    logic                      r_vld;
    hpaw_pkg::t_err_word       r_word;
    logic signed [AW-1:0]      r_prev_err;
    logic signed [SW-1:0]      r_err_sum;

    hpaw_pkg::t_err_word       n_word;
    logic signed [WW-1:0]      n_diff;
    logic signed [WW-1:0]      n_ddiff;
    logic signed [XW-1:0]      n_sum_raw;
    logic                      take;

    assign o_rdy = !r_vld || i_nxt_rdy;
    assign take  = i_vld && o_rdy;

    always_comb begin
        n_diff     = WW'(i_word.target_heading) - WW'(i_word.measured_heading);
        n_word.err = f_wrap(n_diff);
        n_ddiff    = WW'(n_word.err) - WW'(r_prev_err);
        n_word.derr = f_wrap(n_ddiff);
        n_sum_raw  = XW'(r_err_sum) + XW'(n_word.err);
        // upper limit wins when the limits are crossed
        if (n_sum_raw > XW'(i_cfg.integral_upper)) begin
            n_word.sum = i_cfg.integral_upper;
        end else if (n_sum_raw < XW'(i_cfg.integral_lower)) begin
            n_word.sum = i_cfg.integral_lower;
        end else begin
            n_word.sum = n_sum_raw[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (take) begin
                r_prev_err <= n_word.err;
                r_err_sum  <= n_word.sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

// ===== rtl/core/hpaw_mul_stage.sv =====
// ---------------------------------------------------------------------------
// hpaw_mul_stage
// the three gain products, registered
// ---------------------------------------------------------------------------
module hpaw_mul_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  hpaw_pkg::t_err_word   i_word,
    input  hpaw_pkg::t_cfg        i_cfg,
    input  logic                  i_nxt_rdy,
    output logic                  o_rdy,
    output logic                  o_vld,
    output hpaw_pkg::t_prod_word  o_word
);

    localparam int PW = hpaw_pkg::PROD_P_W;
    localparam int IW = hpaw_pkg::PROD_I_W;
    localparam int DW = hpaw_pkg::PROD_D_W;

    logic                  r_vld;
    hpaw_pkg::t_prod_word  r_word;
    hpaw_pkg::t_prod_word  n_word;
    logic                  take;

    assign o_rdy = !r_vld || i_nxt_rdy;
    assign take  = i_vld && o_rdy;

    always_comb begin
        n_word.prod_p = PW'(i_cfg.gain_p) * PW'(i_word.err);
        n_word.prod_i = IW'(i_cfg.gain_i) * IW'(i_word.sum);
        n_word.prod_d = DW'(i_cfg.gain_d) * DW'(i_word.derr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

// ===== rtl/core/hpaw_out_stage.sv =====
// ---------------------------------------------------------------------------
// hpaw_out_stage
// sum of products, fraction drop and drive clamp into the result register
// ---------------------------------------------------------------------------
module hpaw_out_stage #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  hpaw_pkg::t_prod_word  i_word,
    input  hpaw_pkg::t_cfg        i_cfg,
    input  logic                  i_nxt_rdy,
    output logic                  o_rdy,
    output logic                  o_vld,
    output hpaw_pkg::t_out_word   o_word
);

    localparam int CW = hpaw_pkg::ACC_W;
    localparam int DW = hpaw_pkg::DRIVE_W;

    logic                  r_vld;
    hpaw_pkg::t_out_word   r_word;
    hpaw_pkg::t_out_word   n_word;
    logic signed [CW-1:0]  n_acc;
    logic signed [CW-1:0]  n_shift;
    logic                  take;

    assign o_rdy = !r_vld || i_nxt_rdy;
    assign take  = i_vld && o_rdy;

    always_comb begin
        n_acc   = CW'(i_word.prod_p) + CW'(i_word.prod_i) + CW'(i_word.prod_d);
        // arithmetic shift rounds toward minus infinity
        n_shift = n_acc >>> GAIN_FRAC_BITS;
        if (n_shift > CW'(i_cfg.drive_upper)) begin
            n_word.drive_value     = i_cfg.drive_upper;
            n_word.drive_saturated = 1'b1;
        end else if (n_shift < CW'(i_cfg.drive_lower)) begin
            n_word.drive_value     = i_cfg.drive_lower;
            n_word.drive_saturated = 1'b1;
        end else begin
            n_word.drive_value     = n_shift[DW-1:0];
            n_word.drive_saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

// ===== rtl/core/heading_pid_angle_wrap.sv =====
// ---------------------------------------------------------------------------
// heading_pid_angle_wrap
// PID heading correction with wrapped error; one control tick per word
// ---------------------------------------------------------------------------
// A word is taken every cycle while the pipeline moves. It passes four
// registers: input, error (wrap, error change, clamped integral and the
// stored controller state), products, and result, which drives o_word. The
// integral and last-error feedback closes inside the error stage, which
// is what lets ticks follow back to back. A stall at the output fills the
// empty stages before o_ready falls, so up to four words can be in flight.
// Write the gain and clamp registers only while no word is in flight.
module heading_pid_angle_wrap #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  hpaw_pkg::t_in_word                i_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output hpaw_pkg::t_out_word               o_word,
    input  logic                              i_cfg_wr_en,
    input  logic [hpaw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hpaw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    hpaw_pkg::t_cfg        cfg;

    logic                  r_in_vld;
    hpaw_pkg::t_in_word    r_in_word;

    logic                  err_rdy;
    logic                  err_vld;
    hpaw_pkg::t_err_word   err_word;
    logic                  mul_rdy;
    logic                  mul_vld;
    hpaw_pkg::t_prod_word  mul_word;
    logic                  out_rdy;

    hpaw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_ready = !r_in_vld || err_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_word <= i_word;
        end
    end

    hpaw_err_stage u_err (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_in_vld),
        .i_word    (r_in_word),
        .i_cfg     (cfg),
        .i_nxt_rdy (mul_rdy),
        .o_rdy     (err_rdy),
        .o_vld     (err_vld),
        .o_word    (err_word)
    );

    hpaw_mul_stage u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (err_vld),
        .i_word    (err_word),
        .i_cfg     (cfg),
        .i_nxt_rdy (out_rdy),
        .o_rdy     (mul_rdy),
        .o_vld     (mul_vld),
        .o_word    (mul_word)
    );

    hpaw_out_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (mul_vld),
        .i_word    (mul_word),
        .i_cfg     (cfg),
        .i_nxt_rdy (i_ready),
        .o_rdy     (out_rdy),
        .o_vld     (o_valid),
        .o_word    (o_word)
    );

endmodule

// ===== rtl/core/hpaw_chk.sv =====
// ---------------------------------------------------------------------------
// hpaw_chk
// port-level checks of the heading controller, bound to the top level
// ---------------------------------------------------------------------------
`include "heading_pid_angle_wrap_assert.svh"

module hpaw_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  hpaw_pkg::t_out_word  o_word
);

    localparam logic [2:0] DEPTH = 3'd4;

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_take;
    logic       out_take;

    assign in_take  = i_valid && o_ready;
    assign out_take = o_valid && i_ready;

    // words in flight
    always_comb begin
        n_cnt = r_cnt;
        if (in_take && !out_take) begin
            n_cnt = r_cnt + 3'd1;
        end else if (out_take && !in_take) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `HPAW_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_word))
    `HPAW_ASSERT_IMPL(a_no_extra_word, o_valid, r_cnt != 3'd0)
    `HPAW_ASSERT_IMPL(a_depth_bound, 1'b1, r_cnt <= DEPTH)
    `HPAW_ASSERT_IMPL(a_full_stall, (r_cnt == DEPTH) && !i_ready, !o_ready)

endmodule

bind heading_pid_angle_wrap hpaw_chk u_hpaw_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_word  (o_word)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// heading controller bench: random and corner heading words are pushed
// through the valid/ready input while the output side stalls at random.
// Every taken word is scored against an in-bench PID predictor, including
// error wrap, integral and drive clamps. The run steps through several
// gain and clamp settings.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int GAIN_FRAC  = 8;
    localparam int HALF_TURN  = 18000;
    localparam int FULL_TURN  = 36000;
    localparam int LONG_HOLD  = 300;
    localparam int MAX_CYCLES = 200000;
    localparam logic [hpaw_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    hpaw_pkg::t_in_word              i_word      = '0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    hpaw_pkg::t_out_word             o_word;
    logic                            i_cfg_wr_en = 1'b0;
    logic [hpaw_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [hpaw_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor copy of the registers and the controller state
    hpaw_pkg::t_cfg                      cfg_m    = hpaw_pkg::CFG_RESET;
    logic signed [hpaw_pkg::ANGLE_W-1:0] last_err = '0;
    logic signed [hpaw_pkg::SUM_W-1:0]   err_acc  = '0;

    hpaw_pkg::t_in_word  heading_q[$];
    hpaw_pkg::t_out_word drive_q[$];

    int gap_left;
    int stall_left;
    int hold_req;
    int hold_seen;
    int mismatches;
    int cycle_cnt;
    bit quiet;

    heading_pid_angle_wrap #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int wrap_turn(int a);
        int r;
        r = a;
        while (r > HALF_TURN) r -= FULL_TURN;
        while (r < -HALF_TURN) r += FULL_TURN;
        return r;
    endfunction

    function automatic hpaw_pkg::t_out_word control_tick(hpaw_pkg::t_in_word w);
        int                  e;
        int                  de;
        int                  s;
        longint              acc;
        longint              drv;
        hpaw_pkg::t_out_word r;
        e  = wrap_turn(int'($signed(w.target_heading)) - int'($signed(w.measured_heading)));
        de = wrap_turn(e - int'($signed(last_err)));
        s  = int'($signed(err_acc)) + e;
        // upper test wins when the limits are crossed
        if (s > int'($signed(cfg_m.integral_upper))) begin
            s = int'($signed(cfg_m.integral_upper));
        end else if (s < int'($signed(cfg_m.integral_lower))) begin
            s = int'($signed(cfg_m.integral_lower));
        end
        err_acc  = s[hpaw_pkg::SUM_W-1:0];
        last_err = e[hpaw_pkg::ANGLE_W-1:0];
        acc = longint'($signed(cfg_m.gain_p)) * e
            + longint'($signed(cfg_m.gain_i)) * s
            + longint'($signed(cfg_m.gain_d)) * de;
        drv = acc >>> GAIN_FRAC;
        r.drive_saturated = 1'b0;
        if (drv > longint'($signed(cfg_m.drive_upper))) begin
            drv = longint'($signed(cfg_m.drive_upper));
            r.drive_saturated = 1'b1;
        end else if (drv < longint'($signed(cfg_m.drive_lower))) begin
            drv = longint'($signed(cfg_m.drive_lower));
            r.drive_saturated = 1'b1;
        end
        r.drive_value = drv[hpaw_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [hpaw_pkg::ANGLE_W-1:0] pick_heading();
        int k;
        k = $urandom_range(0, 99);
        if (k < 8) begin
            return hpaw_pkg::ANGLE_W'($urandom);
        end else if (k < 14) begin
            return hpaw_pkg::ANGLE_W'(HALF_TURN * rand_span(-1, 1));
        end
        return hpaw_pkg::ANGLE_W'(rand_span(-HALF_TURN, HALF_TURN));
    endfunction

    task automatic check_drive(hpaw_pkg::t_out_word got);
        hpaw_pkg::t_out_word want;
        if (drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected drive word: value %0d sat %0b",
                         $signed(got.drive_value), got.drive_saturated);
            return;
        end
        want = drive_q.pop_front();
        if (got.drive_value !== want.drive_value ||
            got.drive_saturated !== want.drive_saturated) begin
            mismatches++;
            if (mismatches <= 10)
                $display("drive word: expected value %0d sat %0b, got value %0d sat %0b",
                         $signed(want.drive_value), want.drive_saturated,
                         $signed(got.drive_value), got.drive_saturated);
        end
    endtask

    task automatic write_reg(logic [hpaw_pkg::CFG_IDX_W-1:0] idx,
                             logic [hpaw_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        case (idx)
            hpaw_pkg::CFG_GAIN_P:
                cfg_m.gain_p         = data[hpaw_pkg::GAIN_W-1:0];
            hpaw_pkg::CFG_GAIN_I:
                cfg_m.gain_i         = data[hpaw_pkg::GAIN_W-1:0];
            hpaw_pkg::CFG_GAIN_D:
                cfg_m.gain_d         = data[hpaw_pkg::GAIN_W-1:0];
            hpaw_pkg::CFG_INTEGRAL_UPPER:
                cfg_m.integral_upper = data[hpaw_pkg::SUM_W-1:0];
            hpaw_pkg::CFG_INTEGRAL_LOWER:
                cfg_m.integral_lower = data[hpaw_pkg::SUM_W-1:0];
            hpaw_pkg::CFG_DRIVE_UPPER:
                cfg_m.drive_upper    = data[hpaw_pkg::DRIVE_W-1:0];
            hpaw_pkg::CFG_DRIVE_LOWER:
                cfg_m.drive_lower    = data[hpaw_pkg::DRIVE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // junk in the upper byte of the 16-bit registers must be dropped
    task automatic write_all(int kp, int ki, int kd, int iu, int il, int du, int dl);
        write_reg(hpaw_pkg::CFG_GAIN_P,         {8'($urandom), 16'(kp)});
        write_reg(hpaw_pkg::CFG_GAIN_I,         {8'($urandom), 16'(ki)});
        write_reg(hpaw_pkg::CFG_GAIN_D,         {8'($urandom), 16'(kd)});
        write_reg(hpaw_pkg::CFG_INTEGRAL_UPPER, 24'(iu));
        write_reg(hpaw_pkg::CFG_INTEGRAL_LOWER, 24'(il));
        write_reg(hpaw_pkg::CFG_DRIVE_UPPER,    {8'($urandom), 16'(du)});
        write_reg(hpaw_pkg::CFG_DRIVE_LOWER,    {8'($urandom), 16'(dl)});
    endtask

    task automatic push_pair(int tgt, int meas);
        hpaw_pkg::t_in_word w;
        w.target_heading   = hpaw_pkg::ANGLE_W'(tgt);
        w.measured_heading = hpaw_pkg::ANGLE_W'(meas);
        heading_q.push_back(w);
    endtask

    task automatic push_random(int n);
        int                 left;
        int                 run;
        int                 tgt;
        int                 off;
        int                 i;
        hpaw_pkg::t_in_word w;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 3) != 0) begin
                w.target_heading   = pick_heading();
                w.measured_heading = pick_heading();
                heading_q.push_back(w);
                left--;
            end else begin
                // held target, heading sits off to one side so the integral winds up
                run = $urandom_range(8, 40);
                if (run > left) run = left;
                tgt = rand_span(-HALF_TURN, HALF_TURN);
                off = rand_span(-HALF_TURN, HALF_TURN);
                for (i = 0; i < run; i++) begin
                    push_pair(tgt, wrap_turn(tgt - off + rand_span(-100, 100)));
                end
                left -= run;
            end
        end
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic drain();
        while (heading_q.size() != 0 || i_valid || drive_q.size() != 0) @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // input driver, predicts at each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                drive_q.push_back(control_tick(i_word));
                gap_left = quiet ? 0 : $urandom_range(0, 9);
            end
            if (i_valid && !o_ready) begin
                // word holds until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (heading_q.size() != 0) begin
                i_word  <= heading_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output monitor and ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_drive(o_word);
                stall_left = quiet ? 0 : $urandom_range(0, 9);
            end
            if (hold_seen != hold_req) begin
                hold_seen  = hold_req;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("heading_pid_angle_wrap: mismatch");
        $finish;
    end

    initial begin
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unity proportional gain, so the drive shows the wrapped error within the reset drive clamps
        push_pair(0, 0);
        push_pair(HALF_TURN, 0);
        push_pair(0, HALF_TURN);
        push_pair(-HALF_TURN, 0);
        push_pair(0, -HALF_TURN);
        push_pair(HALF_TURN, -HALF_TURN);
        push_pair(-HALF_TURN, HALF_TURN);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(32767, 0);
        push_pair(-32768, 0);
        push_pair(HALF_TURN + 1, 0);
        push_pair(-HALF_TURN - 1, 0);
        push_pair(100, -50);
        push_pair(-9000, 9000);
        drain();

        write_all(rand_span(-2048, 2048), rand_span(-64, 64), rand_span(-1024, 1024),
                  rand_span(100000, 2000000), rand_span(-2000000, -100000),
                  rand_span(1000, 30000), rand_span(-30000, -1000));
        push_random(150);
        drain();

        // extreme gains and limits, no idling on either side
        quiet = 1'b1;
        write_all(32767, -32768, 32767, 8388607, -8388608, 32767, -32768);
        write_reg(CFG_IDX_SPARE, 24'($urandom));
        push_pair(HALF_TURN, -HALF_TURN);
        push_pair(-32768, 32767);
        push_pair(32767, -32768);
        push_pair(HALF_TURN, 0);
        push_pair(0, HALF_TURN);
        push_pair(0, 0);
        push_random(60);
        drain();
        write_all(-32768, 32767, -32768, 8388607, -8388608, 32767, -32768);
        push_random(40);
        drain();
        quiet = 1'b0;

        // crossed integral and drive limits
        write_all(rand_span(-2048, 2048), rand_span(-256, 256), rand_span(-1024, 1024),
                  -5000, 5000, -200, 300);
        push_random(80);
        drain();

        // tight limits, output held off long enough to back up the input
        write_all(128, 256, 64, 20000, -20000, 500, -500);
        hold_req++;
        push_random(100);
        drain();

        for (k = 0; k < 4; k++) begin
            write_all(rand_span(-32768, 32767), rand_span(-32768, 32767),
                      rand_span(-32768, 32767), rand_span(-8388608, 8388607),
                      rand_span(-8388608, 8388607), rand_span(-32768, 32767),
                      rand_span(-32768, 32767));
            push_random(40);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (drive_q.size() != 0) mismatches += drive_q.size();
        if (mismatches == 0) begin
            $display("heading_pid_angle_wrap: match");
        end else begin
            $display("heading_pid_angle_wrap: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hpaw_pkg.sv
rtl/core/hpaw_cfg_regs.sv
rtl/core/hpaw_err_stage.sv
rtl/core/hpaw_mul_stage.sv
rtl/core/hpaw_out_stage.sv
rtl/core/heading_pid_angle_wrap.sv
rtl/core/hpaw_chk.sv
tb/tb_top.sv
